// ===== rtl/mde_pkg.sv =====
package mde_pkg;

    localparam int COORD_W = 16;
    localparam int COEF_W = 16;
    localparam int THR_W = 20;
    localparam int SLOT_W = 4;
    localparam int VIDX_W = 16;
    localparam int DELTA_W = 3 * COORD_W;
    localparam int SQ_W = 38;

    localparam logic [2:0] CFG_POS_X = 3'd0;
    localparam logic [2:0] CFG_POS_Y = 3'd1;
    localparam logic [2:0] CFG_POS_Z = 3'd2;
    localparam logic [2:0] CFG_NRM_X = 3'd3;
    localparam logic [2:0] CFG_NRM_Y = 3'd4;
    localparam logic [2:0] CFG_NRM_Z = 3'd5;
    localparam logic [2:0] CFG_UVW_CNT = 3'd6;
    localparam logic [2:0] CFG_THRESH = 3'd7;

    localparam logic [SLOT_W-1:0] SLOT_POSITION = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_NORMAL = 4'd1;

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic [SLOT_W-1:0] last_slot;
    } run_req_t;

    // saturate a 19-bit signed difference to 16 bits
    function automatic logic [COORD_W-1:0] sat16(input logic signed [18:0] v);
        logic [COORD_W-1:0] r;
        if (v > 19'sd32767) begin
            r = 16'h7fff;
        end else if (v < -19'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/mde_xform.sv =====
// one attribute per start: products registered, then sum, round, delta, length from them
module mde_xform (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [1:0]                   kind,
    input  logic [3*mde_pkg::COORD_W-1:0] base,
    input  logic [3*mde_pkg::COORD_W-1:0] moved,
    input  logic [3*64-1:0]              rows,
    input  logic [mde_pkg::THR_W-1:0]    thr,
    output logic                         done,
    output logic                         keep,
    output logic [mde_pkg::DELTA_W-1:0]  delta
);
    import mde_pkg::*;

    logic signed [31:0] prod_reg [9];
    logic signed [31:0] prod_next [9];
    logic [3*COORD_W-1:0] base_reg, moved_reg;
    logic [3*COORD_W-1:0] trans_reg;
    logic [1:0] kind_reg;
    logic [THR_W-1:0] thr_reg;
    logic busy_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[r*3+k] = $signed(rows[r*64 + k*16 +: 16])
                                 * $signed(moved[k*16 +: 16]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= start;
        end
        if (start) begin
            for (int i = 0; i < 9; i++) prod_reg[i] <= prod_next[i];
            base_reg <= base;
            moved_reg <= moved;
            kind_reg <= kind;
            thr_reg <= thr;
            for (int r = 0; r < 3; r++) trans_reg[r*16 +: 16] <= rows[r*64 + 48 +: 16];
        end
    end

    logic signed [18:0] d [3];
    logic [SQ_W-1:0] sq;

    always_comb begin
        logic signed [34:0] acc;
        logic signed [20:0] t;
        sq = '0;
        for (int r = 0; r < 3; r++) begin
            acc = 35'(prod_reg[r*3]) + 35'(prod_reg[r*3+1]) + 35'(prod_reg[r*3+2])
                + 35'sd8192;
            // arithmetic shift floors
            t = 21'(acc >>> 14);
            if (kind_reg == 2'd0) begin
                t = t + 21'($signed(trans_reg[r*16 +: 16]));
            end else if (kind_reg != 2'd1) begin
                t = 21'($signed(moved_reg[r*16 +: 16]));
            end
            d[r] = 19'(t - 21'($signed(base_reg[r*16 +: 16])));
            sq = sq + SQ_W'(unsigned'(38'(d[r]) * 38'(d[r])));
        end
    end

    assign done = busy_reg;
    assign keep = sq > SQ_W'(thr_reg);
    always_comb begin
        for (int r = 0; r < 3; r++) delta[r*16 +: 16] = keep ? sat16(d[r]) : '0;
    end
endmodule

// ===== rtl/mde_emit.sv =====
// delta buffer memory and run readout
module mde_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [mde_pkg::SLOT_W-1:0]    wr_slot,
    input  logic [mde_pkg::DELTA_W-1:0]   wr_data,
    input  logic                          run_start,
    input  mde_pkg::run_req_t             run_req,
    output logic                          busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata, // vertex_index, slot, delta_x/y/z, pad
    output logic                          m_tlast
);
    import mde_pkg::*;

    logic [DELTA_W-1:0] mem [10];
    logic [DELTA_W-1:0] rd_reg;
    logic [SLOT_W-1:0] rd_slot_reg, out_slot_reg;
    logic rd_pend_reg, active_reg, ovalid_reg;
    run_req_t req_reg;

    logic can_issue;
    assign can_issue = active_reg && !rd_pend_reg && (!ovalid_reg || m_tready);

    // read data is held until the word it belongs to has been taken
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_slot] <= wr_data;
        if (can_issue) rd_reg <= mem[rd_slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            if (ovalid_reg && m_tready) ovalid_reg <= 1'b0;
            if (run_start) begin
                active_reg <= 1'b1;
                rd_slot_reg <= '0;
                req_reg <= run_req;
            end else if (can_issue) begin
                rd_pend_reg <= 1'b1;
                out_slot_reg <= rd_slot_reg;
                if (rd_slot_reg == req_reg.last_slot) active_reg <= 1'b0;
                else rd_slot_reg <= rd_slot_reg + 1'b1;
            end
            if (rd_pend_reg) begin
                rd_pend_reg <= 1'b0;
                ovalid_reg <= 1'b1;
            end
        end
    end

    assign busy = active_reg || rd_pend_reg || ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = {4'b0, rd_reg, out_slot_reg, req_reg.vidx};
    assign m_tlast = out_slot_reg == req_reg.last_slot;
endmodule

// ===== rtl/morph_delta_extract.sv =====
// morph target delta extractor
// s_ channel: one attribute word per vertex attribute (position, normal, uvw...),
// tdata = base x/y/z, moved x/y/z; tuser = span_start, restarting slot and vertex.
// each attribute passes through the shared multiply/length unit, and the
// next word is taken once that result is written into the delta memory.
// after a vertex's last attribute, if any delta passed its threshold, the
// run of slot 0..last is read back from the delta memory, one word at a time,
// on the m_ channel (tdata = vertex_index, slot, delta x/y/z; tlast ends run).
// no input is taken while a run is being read out; a stalled m_ side holds
// the current word and pauses the readout.
// reset restores identity transforms, zero uvw channels, default thresholds
// and clears slot, vertex counter and hit flag. the delta memory is not cleared.
module morph_delta_extract #(
    parameter int MAX_UVW_CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata, // base_x, base_y, base_z, moved_x, moved_y, moved_z
    input  logic        s_tuser, // span_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata, // vertex_index, slot, delta_x, delta_y, delta_z, pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import mde_pkg::*;

    logic [63:0] pos_reg [3];
    logic [47:0] nrm_reg [3];
    logic [3:0]  uvw_reg;
    logic [59:0] thr_all_reg;
    logic [SLOT_W-1:0] slot_reg, cur_slot_reg, last_reg;
    logic [VIDX_W-1:0] vidx_reg;
    logic any_reg, busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg[0] <= 64'd16384;
            pos_reg[1] <= 64'd16384 << 16;
            pos_reg[2] <= 64'd16384 << 32;
            nrm_reg[0] <= 48'd16384;
            nrm_reg[1] <= 48'd16384 << 16;
            nrm_reg[2] <= 48'd16384 << 32;
            uvw_reg <= '0;
            thr_all_reg <= 60'd11028101333097;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_POS_X: pos_reg[0] <= cfg_data;
                CFG_POS_Y: pos_reg[1] <= cfg_data;
                CFG_POS_Z: pos_reg[2] <= cfg_data;
                CFG_NRM_X: nrm_reg[0] <= cfg_data[47:0];
                CFG_NRM_Y: nrm_reg[1] <= cfg_data[47:0];
                CFG_NRM_Z: nrm_reg[2] <= cfg_data[47:0];
                CFG_UVW_CNT: uvw_reg <= cfg_data[3:0];
                CFG_THRESH: thr_all_reg <= cfg_data[59:0];
                default: ;
            endcase
        end
    end

    logic [SLOT_W-1:0] chans, last_slot, s_eff, s_raw;
    logic [1:0] kind;
    logic [3*64-1:0] rows;
    logic [THR_W-1:0] thr;
    logic acc_in, emit_busy, x_done, x_keep;
    logic [DELTA_W-1:0] x_delta;

    assign chans = (uvw_reg > SLOT_W'(MAX_UVW_CHANNELS)) ? SLOT_W'(MAX_UVW_CHANNELS) : uvw_reg;
    assign last_slot = chans + 1'b1;
    assign s_raw = s_tuser ? '0 : slot_reg;
    assign s_eff = (s_raw > last_slot) ? last_slot : s_raw;
    assign kind = (s_eff == SLOT_POSITION) ? 2'd0 : (s_eff == SLOT_NORMAL) ? 2'd1 : 2'd2;
    assign rows = (kind == 2'd0) ? {pos_reg[2], pos_reg[1], pos_reg[0]}
                : {16'h0, nrm_reg[2], 16'h0, nrm_reg[1], 16'h0, nrm_reg[0]};
    assign thr = thr_all_reg[20*kind +: 20];

    assign s_tready = !busy_reg && !emit_busy;
    assign acc_in = s_tvalid && s_tready;

    mde_xform u_xform (
        .aclk(aclk), .aresetn(aresetn), .start(acc_in), .kind(kind),
        .base(s_tdata[47:0]), .moved(s_tdata[95:48]), .rows(rows), .thr(thr),
        .done(x_done), .keep(x_keep), .delta(x_delta)
    );

    logic any_now, fin;
    run_req_t req;
    assign any_now = any_reg || x_keep;
    assign fin = x_done && (cur_slot_reg == last_reg);
    assign req.vidx = vidx_reg;
    assign req.last_slot = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
            vidx_reg <= '0;
            any_reg <= 1'b0;
        end else begin
            if (acc_in) begin
                busy_reg <= 1'b1;
                cur_slot_reg <= s_eff;
                last_reg <= last_slot;
                if (s_tuser) begin
                    vidx_reg <= '0;
                    any_reg <= 1'b0;
                end
            end
            if (x_done) begin
                busy_reg <= 1'b0;
                if (fin) begin
                    slot_reg <= '0;
                    any_reg <= 1'b0;
                    vidx_reg <= vidx_reg + 1'b1;
                end else begin
                    slot_reg <= cur_slot_reg + 1'b1;
                    any_reg <= any_now;
                end
            end
        end
    end

    mde_emit u_emit (
        .aclk(aclk), .aresetn(aresetn), .wr_en(x_done), .wr_slot(cur_slot_reg),
        .wr_data(x_delta), .run_start(fin && any_now), .run_req(req),
        .busy(emit_busy), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    a_no_accept_in_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_busy |-> !s_tready) else $error("input taken during readout");
    a_done_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_in |=> x_done) else $error("unit result missing");
    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:16] <= 4'd9) else $error("slot out of range");
endmodule

// ===== verif/morph_delta_extract_test.sv =====
`timescale 1ns / 100ps

module morph_delta_extract_test;
    import mde_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [15:0] vidx;
        logic [3:0]  slot;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        logic        last;
    } delta_word_t;

    // expected-word tracker: mirrors registers and per-vertex state of the extractor
    class delta_scoreboard;
        logic [63:0] pos_row [3];
        logic [47:0] nrm_row [3];
        logic [3:0]  chan_cnt;
        logic [59:0] thr_pack;
        int          next_slot;
        logic [15:0] vcount;
        bit          hit;
        logic [47:0] delta_mem [10];
        delta_word_t pending_words [$];
        int          errors;

        function new();
            pos_row[0] = 64'd16384;
            pos_row[1] = 64'd16384 << 16;
            pos_row[2] = 64'd16384 << 32;
            for (int k = 0; k < 3; k++) nrm_row[k] = pos_row[k][47:0];
            chan_cnt = '0;
            thr_pack = 60'd11028101333097;
            next_slot = 0;
            vcount = '0;
            hit = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                CFG_POS_X: pos_row[0] = v;
                CFG_POS_Y: pos_row[1] = v;
                CFG_POS_Z: pos_row[2] = v;
                CFG_NRM_X: nrm_row[0] = v[47:0];
                CFG_NRM_Y: nrm_row[1] = v[47:0];
                CFG_NRM_Z: nrm_row[2] = v[47:0];
                CFG_UVW_CNT: chan_cnt = v[3:0];
                CFG_THRESH: thr_pack = v[59:0];
                default: ;
            endcase
        endfunction

        function longint transform(logic [47:0] row, longint mv [3]);
            longint acc;
            acc = 0;
            for (int j = 0; j < 3; j++) acc += longint'($signed(row[16*j +: 16])) * mv[j];
            return (acc + 8192) >>> 14;
        endfunction

        function logic [15:0] clip16(longint v);
            if (v > 32767) return 16'h7fff;
            if (v < -32768) return 16'h8000;
            return v[15:0];
        endfunction

        function void note_attribute(logic [95:0] d, bit start);
            longint bv [3];
            longint mv [3];
            longint dd [3];
            longint t;
            longint unsigned sq;
            logic [19:0] thr;
            int last_slot;
            int s;
            delta_word_t w;
            for (int k = 0; k < 3; k++) begin
                bv[k] = longint'($signed(d[16*k +: 16]));
                mv[k] = longint'($signed(d[48 + 16*k +: 16]));
            end
            if (start) begin
                next_slot = 0;
                vcount = 0;
                hit = 0;
            end
            last_slot = 1 + ((chan_cnt > 8) ? 8 : int'(chan_cnt));
            s = (next_slot > last_slot) ? last_slot : next_slot;
            sq = 0;
            for (int k = 0; k < 3; k++) begin
                if (s == 0)
                    t = transform(pos_row[k][47:0], mv) + longint'($signed(pos_row[k][63:48]));
                else if (s == 1)
                    t = transform(nrm_row[k], mv);
                else
                    t = mv[k];
                dd[k] = t - bv[k];
                sq += longint'(dd[k] * dd[k]);
            end
            thr = (s == 0) ? thr_pack[19:0] : (s == 1) ? thr_pack[39:20] : thr_pack[59:40];
            if (sq > thr) begin
                hit = 1;
                delta_mem[s] = {clip16(dd[2]), clip16(dd[1]), clip16(dd[0])};
            end else begin
                delta_mem[s] = '0;
            end
            if (s < last_slot) begin
                next_slot = s + 1;
                return;
            end
            if (hit) begin
                for (int k = 0; k <= last_slot; k++) begin
                    w.vidx = vcount;
                    w.slot = k[3:0];
                    w.dx = delta_mem[k][15:0];
                    w.dy = delta_mem[k][31:16];
                    w.dz = delta_mem[k][47:32];
                    w.last = (k == last_slot);
                    pending_words.push_back(w);
                end
            end
            next_slot = 0;
            hit = 0;
            vcount++;
        endfunction

        function void check_word(logic [71:0] d, logic last);
            delta_word_t got;
            delta_word_t exp_w;
            got = {d[15:0], d[19:16], d[35:20], d[51:36], d[67:52], last};
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $realtime, got);
                errors++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.vidx !== exp_w.vidx || got.slot !== exp_w.slot || got.dx !== exp_w.dx
                    || got.dy !== exp_w.dy || got.dz !== exp_w.dz || got.last !== exp_w.last) begin
                $display("%0t: mismatch, expected vidx %h slot %h d %h %h %h last %b",
                         $realtime, exp_w.vidx, exp_w.slot, exp_w.dx, exp_w.dy, exp_w.dz,
                         exp_w.last);
                $display("%0t:           actual vidx %h slot %h d %h %h %h last %b",
                         $realtime, got.vidx, got.slot, got.dx, got.dy, got.dz, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    delta_scoreboard sb = new();
    bit calm = 1'b0;
    int stall_count = 0;

    morph_delta_extract u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 15);
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("[morph_delta_extract] ERROR");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send_attr(logic [95:0] d, bit start);
        if (!calm && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= start;
        do @(posedge aclk); while (!s_tready);
        sb.note_attribute(d, start);
    endtask

    // hold the input off until every expected word is out and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    function automatic logic [95:0] pack_attr(logic [15:0] bx, logic [15:0] by,
                                              logic [15:0] bz, logic [15:0] mx,
                                              logic [15:0] my, logic [15:0] mz);
        return {mz, my, mx, bz, by, bx};
    endfunction

    function automatic logic [95:0] random_attr();
        logic [47:0] b;
        logic [47:0] m;
        b = 48'({$urandom, $urandom});
        if ($urandom_range(1)) return {$urandom, $urandom, $urandom};
        // moved close to base so that thresholds matter
        for (int k = 0; k < 3; k++) m[16*k +: 16] = b[16*k +: 16] + 16'($urandom_range(0, 128) - 64);
        return {m, b};
    endfunction

    task automatic random_phase(int n_items);
        int sent;
        int n_attr;
        sent = 0;
        while (sent < n_items) begin
            n_attr = 2 + ((sb.chan_cnt > 8) ? 8 : int'(sb.chan_cnt));
            // a few broken vertices cut short or restarted
            if ($urandom_range(99) < 10) n_attr = $urandom_range(1, n_attr);
            for (int a = 0; a < n_attr; a++) begin
                send_attr(random_attr(), (a == 0) ? ($urandom_range(99) < 10)
                                                  : ($urandom_range(99) < 3));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // saturating position and normal, then a quiet vertex, then one with a small position shift
        send_attr(pack_attr(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff), 1'b1);
        send_attr(pack_attr(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000), 1'b0);
        send_attr('0, 1'b0);
        send_attr('0, 1'b0);
        send_attr(pack_attr(16'd0, 16'd0, 16'd0, 16'd40, 16'd0, 16'd0), 1'b0);
        send_attr('0, 1'b0);
        drain();

        // channel count above the maximum, full ten-slot run
        write_reg(CFG_UVW_CNT, 64'hf);
        for (int a = 0; a < 10; a++) send_attr(random_attr(), a == 0);
        drain();

        // count lowered while a vertex is half way through
        write_reg(CFG_UVW_CNT, 64'd3);
        for (int a = 0; a < 4; a++) send_attr(random_attr(), 1'b0);
        drain();
        write_reg(CFG_UVW_CNT, 64'd0);
        send_attr(random_attr(), 1'b0);
        drain();

        for (int p = 0; p < 4; p++) begin
            for (int r = 0; r < 6; r++) begin
                case (p)
                    0: write_reg(3'(r), '1);
                    1: write_reg(3'(r), 64'h8000_8000_8000_8000);
                    default: write_reg(3'(r), {$urandom, $urandom});
                endcase
            end
            write_reg(CFG_UVW_CNT, (p == 0) ? 64'd8 : 64'($urandom_range(0, 15)));
            case (p)
                0: write_reg(CFG_THRESH, 64'd0);
                1: write_reg(CFG_THRESH, '1);
                default: write_reg(CFG_THRESH, {$urandom, $urandom});
            endcase
            calm = (p == 2);
            random_phase(40);
            drain();
        end
        calm = 1'b0;

        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("[morph_delta_extract] OK");
        end else begin
            $display("[morph_delta_extract] ERROR");
        end
        $finish;
    end

endmodule
